/* rtl/indexed_list_insert_delete_assert.svh */
// assertion macros for the indexed list store
// used by the top level only, no other dependencies
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

// condition that holds at every edge out of reset
`define ILID_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication in the same cycle
`define ILID_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication on the next cycle
`define ILID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ilid_pkg.sv */
// shared types and constants for the indexed list store
// no dependencies
package ilid_pkg;

   localparam int DEPTH_DEFAULT      = 32;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int ADDR_MAX_W         = 10;

   localparam int POS_W   = 6;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 6;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_MAX_W-1:0] wr_addr;
      logic                  rd_en;
      logic [ADDR_MAX_W-1:0] rd_addr;
   } mem_ctl_type;

endpackage

/* rtl/ilid_mem.sv */
// list entry memory: one write port, one read port with registered data
// depends on ilid_pkg
module ilid_mem import ilid_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  mem_ctl_type           ctl,
   input  logic [DATA_WIDTH-1:0] wr_data,
   output logic [DATA_WIDTH-1:0] rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr[AW-1:0]] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ilid_stepper.sv */
// shared pointer unit: steps the shift pointer and detects the end of a shift
// depends on ilid_pkg
module ilid_stepper import ilid_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic [$clog2(DEPTH)-1:0] ptr,
   input  logic [$clog2(DEPTH)-1:0] target,
   input  logic                     dir_up,
   output logic [$clog2(DEPTH)-1:0] next,
   output logic                     hit
);

   localparam int AW = $clog2(DEPTH);

   // moving up reads from below, moving down reads from above
   assign next = dir_up ? (ptr - AW'(1)) : (ptr + AW'(1));
   assign hit  = (ptr == target);

endmodule

/* rtl/indexed_list_insert_delete.sv */
// indexed list store, top level: sequencer, handshake and result register
// append writes at the end, read fetches then captures the entry, full or bad position
// goes straight to completion; insert and delete move each entry by a read then a write
// one item at a time: the next item can be taken in the same cycle that the result appears
// synchronous reset clears the count, the sequencer and rsp_valid; the entry memory is not cleared
// depends on ilid_pkg, ilid_mem, ilid_stepper and indexed_list_insert_delete_assert.svh
`include "indexed_list_insert_delete_assert.svh"
module indexed_list_insert_delete import ilid_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [POS_W-1:0]   req_position,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [VALUE_W-1:0] rsp_read_value,
   output logic [COUNT_W-1:0] rsp_count
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FETCH = 3'd1;
   localparam logic [2:0] S_CAP   = 3'd2;
   localparam logic [2:0] S_STEP  = 3'd3;
   localparam logic [2:0] S_MOVE  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [1:0]            op_ff, op_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [DATA_WIDTH-1:0] result_ff, result_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [AW-1:0]         target_ff, target_in;
   logic                  dir_up_ff, dir_up_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]    rsp_read_value_ff, rsp_read_value_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   mem_ctl_type           mem_ctl;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic [DATA_WIDTH-1:0] mem_rd_data;
   logic [AW-1:0]         step_next;
   logic                  step_hit;

   logic                  accept;
   logic                  full;
   logic                  pos_ok;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic [AW-1:0]         at_addr;
   logic [63:0]           val_wide;
   logic [63:0]           result_wide;
   logic [63:0]           count_wide;
   logic                  rsp_free;
   logic [ADDR_MAX_W:0]   wr_addr_ext;

   ilid_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   ilid_stepper #(
      .DEPTH (DEPTH)
   ) u_stepper (
      .ptr    (ptr_ff),
      .target (target_ff),
      .dir_up (dir_up_ff),
      .next   (step_next),
      .hit    (step_hit)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign full    = (count_ff == CW'(DEPTH));
   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(count_ff);
   assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
   assign at_addr = AW'(pos_ext - CMP_W'(1));

   assign val_wide    = 64'(req_value);
   assign result_wide = 64'(result_ff);

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      op_in             = op_ff;
      status_in         = status_ff;
      val_in            = val_ff;
      result_in         = result_ff;
      ptr_in            = ptr_ff;
      target_in         = target_ff;
      dir_up_in         = dir_up_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_status_in     = rsp_status_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_count_in      = rsp_count_ff;
      mem_ctl           = '0;
      mem_wr_data       = mem_rd_data;
      count_wide        = 64'(count_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_type;
               val_in    = val_wide[DATA_WIDTH-1:0];
               result_in = '0;
               status_in = ST_OK;
               ptr_in    = at_addr;
               target_in = at_addr;
               dir_up_in = 1'b1;
               state_in  = S_DONE;
               unique case (req_type)
                  OP_APPEND: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        ptr_in    = AW'(count_ff);
                        target_in = AW'(count_ff);
                        state_in  = S_STEP;
                     end
                  end
                  OP_INSERT: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else if (!pos_ok) begin
                        status_in = ST_RANGE;
                     end else begin
                        ptr_in   = AW'(count_ff);
                        state_in = S_STEP;
                     end
                  end
                  OP_DELETE: begin
                     if (!pos_ok) begin
                        status_in = ST_RANGE;
                     end else begin
                        target_in = AW'(count_ff - CW'(1));
                        dir_up_in = 1'b0;
                        state_in  = S_FETCH;
                     end
                  end
                  OP_READ: begin
                     if (!pos_ok) begin
                        status_in = ST_RANGE;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                     status_in = ST_RANGE;
                  end
               endcase
            end
         end
         S_FETCH: begin
            mem_ctl.rd_en   = 1'b1;
            mem_ctl.rd_addr = ADDR_MAX_W'(ptr_ff);
            state_in        = S_CAP;
         end
         S_CAP: begin
            result_in = mem_rd_data;
            state_in  = (op_ff == OP_DELETE) ? S_STEP : S_DONE;
         end
         S_STEP: begin
            if (step_hit) begin
               // insert and append end by placing the new value
               if (dir_up_ff) begin
                  mem_ctl.wr_en   = 1'b1;
                  mem_ctl.wr_addr = ADDR_MAX_W'(ptr_ff);
                  mem_wr_data     = val_ff;
               end
               state_in = S_DONE;
            end else begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = ADDR_MAX_W'(step_next);
               state_in        = S_MOVE;
            end
         end
         S_MOVE: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = ADDR_MAX_W'(ptr_ff);
            mem_wr_data     = mem_rd_data;
            ptr_in          = step_next;
            state_in        = S_STEP;
         end
         S_DONE: begin
            if (rsp_free) begin
               if (status_ff == ST_OK) begin
                  if (op_ff == OP_APPEND || op_ff == OP_INSERT) begin
                     count_in = count_ff + CW'(1);
                  end else if (op_ff == OP_DELETE) begin
                     count_in = count_ff - CW'(1);
                  end
               end
               count_wide        = 64'(count_in);
               rsp_valid_in      = 1'b1;
               rsp_status_in     = status_ff;
               rsp_read_value_in = result_wide[VALUE_W-1:0];
               rsp_count_in      = count_wide[COUNT_W-1:0];
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      status_ff         <= status_in;
      val_ff            <= val_in;
      result_ff         <= result_in;
      ptr_ff            <= ptr_in;
      target_ff         <= target_in;
      dir_up_ff         <= dir_up_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_count_ff      <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;

   assign wr_addr_ext = (ADDR_MAX_W + 1)'(mem_ctl.wr_addr);

   `ILID_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "count above depth")
   `ILID_ASSERT_SAME(a_wr_in_range, clock, reset, mem_ctl.wr_en, wr_addr_ext < (ADDR_MAX_W + 1)'(DEPTH), "write beyond depth")
   `ILID_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_read_value == '0, "error item with nonzero value")
   `ILID_ASSERT_NEXT(a_count_hold, clock, reset, state_ff != S_DONE, $stable(count_ff), "count changed outside completion")

endmodule
